>>> sv/nsh_pkg.sv
// Shared constants, command/status types for the nearest sphere hit unit.
package nsh_pkg;

	localparam int NSH_MAX_SPHERES = 16;

	// Port field widths
	localparam int COORD_W   = 32;
	localparam int R2_W      = 31;
	localparam int CFG_W     = 5;
	localparam int IDX_IN_W  = 4;
	localparam int DIST_W    = 31;
	localparam int ENTRY_W   = 3 * COORD_W + R2_W;

	// Internal datapath widths
	localparam int L_W       = COORD_W + 1;  // origin minus center
	localparam int H_W       = 43;           // D.L in Q.24
	localparam int A_W       = 40;           // D.D in Q.24
	localparam int C_W       = 43;           // L.L - r2 in Q.24
	localparam int OPND_W    = 44;           // multiplier operand magnitude
	localparam int LIMB_W    = OPND_W / 2;
	localparam int ACC_W     = 2 * OPND_W;
	localparam int DISC_W    = 84;           // discriminant, Q.48
	localparam int SQ_W      = DISC_W / 2;   // root bits, one per step
	localparam int SR_W      = SQ_W + 3;     // root remainder
	localparam int NUM_W     = 45;           // root numerator
	localparam int Q_W       = DIST_W;       // quotient bits, one per step
	localparam int DIV_W     = 70;           // scaled divider operands
	localparam int STEP_W    = 6;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [DIST_W-1:0] MISS_DIST = '1;

	// Products run in this order on the shared multiplier
	typedef enum logic [3:0] {
		OP_DL_X, OP_DL_Y, OP_DL_Z,
		OP_DD_X, OP_DD_Y, OP_DD_Z,
		OP_LL_X, OP_LL_Y, OP_LL_Z,
		OP_HH, OP_AC
	} mul_op_t;

	typedef struct packed {
		logic    tbl_wr;    // write load beat into the table
		logic    q_load;    // latch query ray, reset best
		logic    ent_load;  // form L from table entry
		logic    mul_step;  // one partial product
		logic [1:0] mul_part;
		mul_op_t mul_op;
		logic    mul_wb;    // write or accumulate product into its target
		logic    sq_step;   // one root bit
		logic    num_calc;  // numerator and divider setup
		logic    dv_step;   // one quotient bit
		logic    upd;       // keep nearest
		logic    out_load;  // move result into output register
	} nsh_cmd_t;

	typedef struct packed {
		logic a_zero;
		logic disc_neg;
		logic num_bad;
	} nsh_sts_t;

endpackage

>>> sv/nearest_sphere_hit_unit.sv
// A load beat writes the table as it is accepted; a query tests each sphere up to the configured
//   count in turn (a sphere rejected early by its discriminant or numerator skips its later steps).
// Per sphere: 11 products on one shared multiplier, each as four limb products and a write-back,
//   a 42-bit square root and a 31-bit quotient, one bit a cycle. One item is in work at a time.
// A finished result waits in the output register while the next beat is accepted.
// Reset (arst_n low) clears control state and the configured sphere count; table contents are kept.
module nearest_sphere_hit_unit #(
	parameter int MAX_SPHERES = nsh_pkg::NSH_MAX_SPHERES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               kind,
	input  logic [nsh_pkg::IDX_IN_W-1:0]       entry_index,
	input  logic signed [nsh_pkg::COORD_W-1:0] center_x,
	input  logic signed [nsh_pkg::COORD_W-1:0] center_y,
	input  logic signed [nsh_pkg::COORD_W-1:0] center_z,
	input  logic [nsh_pkg::R2_W-1:0]           radius_squared,
	input  logic signed [nsh_pkg::COORD_W-1:0] origin_x,
	input  logic signed [nsh_pkg::COORD_W-1:0] origin_y,
	input  logic signed [nsh_pkg::COORD_W-1:0] origin_z,
	input  logic signed [nsh_pkg::COORD_W-1:0] direction_x,
	input  logic signed [nsh_pkg::COORD_W-1:0] direction_y,
	input  logic signed [nsh_pkg::COORD_W-1:0] direction_z,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               hit,
	output logic [nsh_pkg::DIST_W-1:0]         nearest_distance,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [nsh_pkg::CFG_W-1:0]          cfg_data
);
	import nsh_pkg::*;

	localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;

	nsh_cmd_t      cmd;
	nsh_sts_t      sts;
	logic [AW-1:0] rd_addr;

	nsh_ctrl #(.MAX_SPHERES(MAX_SPHERES)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.rd_addr  (rd_addr)
	);

	nsh_datapath #(.MAX_SPHERES(MAX_SPHERES)) u_dp (
		.clk             (clk),
		.cmd             (cmd),
		.sts             (sts),
		.rd_addr         (rd_addr),
		.entry_index     (entry_index),
		.center_x        (center_x),
		.center_y        (center_y),
		.center_z        (center_z),
		.radius_squared  (radius_squared),
		.origin_x        (origin_x),
		.origin_y        (origin_y),
		.origin_z        (origin_z),
		.direction_x     (direction_x),
		.direction_y     (direction_y),
		.direction_z     (direction_z),
		.hit             (hit),
		.nearest_distance(nearest_distance)
	);

endmodule

>>> sv/nsh_ram.sv
// Generic single-port-write, registered-read RAM.
module nsh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> sv/nsh_datapath.sv
// Sphere table, shared multiplier, root and divider units, result registers.
module nsh_datapath #(
	parameter int MAX_SPHERES = nsh_pkg::NSH_MAX_SPHERES,
	localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1
) (
	input  logic                              clk,
	input  nsh_pkg::nsh_cmd_t                 cmd,
	output nsh_pkg::nsh_sts_t                 sts,
	input  logic [AW-1:0]                     rd_addr,
	input  logic [nsh_pkg::IDX_IN_W-1:0]      entry_index,
	input  logic signed [nsh_pkg::COORD_W-1:0] center_x,
	input  logic signed [nsh_pkg::COORD_W-1:0] center_y,
	input  logic signed [nsh_pkg::COORD_W-1:0] center_z,
	input  logic [nsh_pkg::R2_W-1:0]          radius_squared,
	input  logic signed [nsh_pkg::COORD_W-1:0] origin_x,
	input  logic signed [nsh_pkg::COORD_W-1:0] origin_y,
	input  logic signed [nsh_pkg::COORD_W-1:0] origin_z,
	input  logic signed [nsh_pkg::COORD_W-1:0] direction_x,
	input  logic signed [nsh_pkg::COORD_W-1:0] direction_y,
	input  logic signed [nsh_pkg::COORD_W-1:0] direction_z,
	output logic                              hit,
	output logic [nsh_pkg::DIST_W-1:0]        nearest_distance
);
	import nsh_pkg::*;

	function automatic logic [OPND_W-1:0] abs44(input logic [OPND_W-1:0] v);
		return v[OPND_W-1] ? (~v + 1'b1) : v;
	endfunction

	logic [COORD_W-1:0] org_q [3];
	logic [COORD_W-1:0] dir_q [3];
	logic [L_W-1:0]     l_q   [3];
	logic [H_W-1:0]     h_q;
	logic [A_W-1:0]     a_q;
	logic [C_W-1:0]     c_q;
	logic [DISC_W-1:0]  hh_q;
	logic [ACC_W-1:0]   acc_q;
	logic [DISC_W-1:0]  sq_sh_q;
	logic [SR_W-1:0]    sq_rem_q;
	logic [SQ_W-1:0]    sq_root_q;
	logic               disc_neg_q;
	logic               num_bad_q;
	logic [DIV_W-1:0]   dv_r_q;
	logic [DIV_W-1:0]   dv_d_q;
	logic [Q_W-1:0]     dv_q_q;
	logic [DIST_W-1:0]  best_q;
	logic               hit_q;
	logic [DIST_W-1:0]  out_dist_q;
	logic               out_hit_q;

	// Sphere table
	logic [6:0]         idx_ext;
	logic               tbl_we;
	logic [ENTRY_W-1:0] rd_data;
	logic [COORD_W-1:0] cen [3];
	logic [R2_W-1:0]    ent_r2;

	assign idx_ext = 7'(entry_index);
	assign tbl_we  = cmd.tbl_wr && (idx_ext < 7'(MAX_SPHERES));

	nsh_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SPHERES)) u_table (
		.clk    (clk),
		.wr_en  (tbl_we),
		.wr_addr(idx_ext[AW-1:0]),
		.wr_data({center_x, center_y, center_z, radius_squared}),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign cen[0] = rd_data[ENTRY_W-1 -: COORD_W];
	assign cen[1] = rd_data[ENTRY_W-COORD_W-1 -: COORD_W];
	assign cen[2] = rd_data[R2_W+COORD_W-1 -: COORD_W];
	assign ent_r2 = rd_data[R2_W-1:0];

	// Operand magnitudes, sign-extended to the multiplier width
	logic [OPND_W-1:0] abs_d [3];
	logic [OPND_W-1:0] abs_l [3];
	logic [OPND_W-1:0] abs_h, abs_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_d[i] = abs44({{(OPND_W-COORD_W){dir_q[i][COORD_W-1]}}, dir_q[i]});
			abs_l[i] = abs44({{(OPND_W-L_W){l_q[i][L_W-1]}}, l_q[i]});
		end
		abs_h = abs44({{(OPND_W-H_W){h_q[H_W-1]}}, h_q});
		abs_c = abs44({{(OPND_W-C_W){c_q[C_W-1]}}, c_q});
	end

	// Operand select for the shared multiplier
	logic [OPND_W-1:0] opa, opb;
	logic              pneg;

	always_comb begin
		opa  = '0;
		opb  = '0;
		pneg = 1'b0;
		unique case (cmd.mul_op)
			OP_DL_X: begin opa = abs_d[0]; opb = abs_l[0];
				pneg = dir_q[0][COORD_W-1] ^ l_q[0][L_W-1]; end
			OP_DL_Y: begin opa = abs_d[1]; opb = abs_l[1];
				pneg = dir_q[1][COORD_W-1] ^ l_q[1][L_W-1]; end
			OP_DL_Z: begin opa = abs_d[2]; opb = abs_l[2];
				pneg = dir_q[2][COORD_W-1] ^ l_q[2][L_W-1]; end
			OP_DD_X: begin opa = abs_d[0]; opb = abs_d[0]; end
			OP_DD_Y: begin opa = abs_d[1]; opb = abs_d[1]; end
			OP_DD_Z: begin opa = abs_d[2]; opb = abs_d[2]; end
			OP_LL_X: begin opa = abs_l[0]; opb = abs_l[0]; end
			OP_LL_Y: begin opa = abs_l[1]; opb = abs_l[1]; end
			OP_LL_Z: begin opa = abs_l[2]; opb = abs_l[2]; end
			OP_HH:   begin opa = abs_h;    opb = abs_h;    end
			OP_AC:   begin opa = {{(OPND_W-A_W){1'b0}}, a_q}; opb = abs_c; end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	// One limb product per cycle
	logic [LIMB_W-1:0]   limb_a, limb_b;
	logic [2*LIMB_W-1:0] pp;
	logic [ACC_W-1:0]    pp_sh;

	always_comb begin
		limb_a = cmd.mul_part[1] ? opa[OPND_W-1 -: LIMB_W] : opa[LIMB_W-1:0];
		limb_b = cmd.mul_part[0] ? opb[OPND_W-1 -: LIMB_W] : opb[LIMB_W-1:0];
		pp     = limb_a * limb_b;
		unique case (cmd.mul_part)
			2'd0:    pp_sh = ACC_W'(pp);
			2'd3:    pp_sh = ACC_W'(pp) << (2 * LIMB_W);
			default: pp_sh = ACC_W'(pp) << LIMB_W;
		endcase
	end

	// Signed product rounded toward minus infinity to Q.24
	logic signed [ACC_W:0] sprod;
	logic signed [ACC_W:0] sprod_fl;
	logic [DISC_W-1:0]     ac;
	logic                  c_neg;

	always_comb begin
		sprod    = pneg ? ((ACC_W+1)'(0) - {1'b0, acc_q}) : {1'b0, acc_q};
		sprod_fl = sprod >>> 24;
		ac       = acc_q[DISC_W-1:0];
		c_neg    = c_q[C_W-1];
	end

	// Numerator of the chosen root
	logic signed [NUM_W-1:0] nh, nn, nf, num;
	logic                    num_bad;

	always_comb begin
		nh  = (NUM_W)'(0) - {{(NUM_W-H_W){h_q[H_W-1]}}, h_q};
		nn  = nh - {{(NUM_W-SQ_W){1'b0}}, sq_root_q};
		nf  = nh + {{(NUM_W-SQ_W){1'b0}}, sq_root_q};
		num = nn[NUM_W-1] ? nf : nn;
		num_bad = num[NUM_W-1] || (num == '0) ||
			({3'b0, num} >= {1'b0, a_q, 7'b0});
	end

	// Root and divider step logic
	logic [SR_W-1:0] rem_n, trial;
	logic            sq_fit, dv_fit;

	always_comb begin
		rem_n  = {sq_rem_q[SR_W-3:0], sq_sh_q[DISC_W-1 -: 2]};
		trial  = {1'b0, sq_root_q, 2'b01};
		sq_fit = rem_n >= trial;
		dv_fit = dv_r_q >= dv_d_q;
	end

	always_ff @(posedge clk) begin
		// Query latch
		if (cmd.q_load) begin
			org_q[0] <= origin_x;
			org_q[1] <= origin_y;
			org_q[2] <= origin_z;
			dir_q[0] <= direction_x;
			dir_q[1] <= direction_y;
			dir_q[2] <= direction_z;
			best_q   <= MISS_DIST;
			hit_q    <= 1'b0;
		end

		// Entry setup
		if (cmd.ent_load) begin
			for (int i = 0; i < 3; i++) begin
				l_q[i] <= {org_q[i][COORD_W-1], org_q[i]} - {cen[i][COORD_W-1], cen[i]};
			end
			h_q <= '0;
			a_q <= '0;
			c_q <= C_W'(0) - {{(C_W-R2_W){1'b0}}, ent_r2};
		end

		// Partial products
		if (cmd.mul_step) begin
			acc_q <= (cmd.mul_part == 2'd0) ? pp_sh : (acc_q + pp_sh);
		end

		// Product write-back
		if (cmd.mul_wb) begin
			unique case (cmd.mul_op)
				OP_DL_X, OP_DL_Y, OP_DL_Z: h_q <= h_q + sprod_fl[H_W-1:0];
				OP_DD_X, OP_DD_Y, OP_DD_Z: a_q <= a_q + acc_q[24 +: A_W];
				OP_LL_X, OP_LL_Y, OP_LL_Z:
					c_q <= c_q + {{(C_W-41){1'b0}}, acc_q[24 +: 41]};
				OP_HH: hh_q <= acc_q[DISC_W-1:0];
				OP_AC: begin
					disc_neg_q <= !c_neg && (hh_q < ac);
					sq_sh_q    <= c_neg ? (hh_q + ac) : (hh_q - ac);
					sq_rem_q   <= '0;
					sq_root_q  <= '0;
				end
				default: hh_q <= hh_q;
			endcase
		end

		// Square root, one bit a step
		if (cmd.sq_step) begin
			sq_sh_q   <= {sq_sh_q[DISC_W-3:0], 2'b00};
			sq_rem_q  <= sq_fit ? (rem_n - trial) : rem_n;
			sq_root_q <= {sq_root_q[SQ_W-2:0], sq_fit};
		end

		// Numerator and divider setup
		if (cmd.num_calc) begin
			num_bad_q <= num_bad;
			dv_r_q    <= {2'b00, num[NUM_W-2:0], 24'b0};
			dv_d_q    <= {a_q, 30'b0};
			dv_q_q    <= '0;
		end

		// Division, one quotient bit a step
		if (cmd.dv_step) begin
			if (dv_fit) begin
				dv_r_q <= dv_r_q - dv_d_q;
			end
			dv_d_q <= dv_d_q >> 1;
			dv_q_q <= {dv_q_q[Q_W-2:0], dv_fit};
		end

		// Nearest so far
		if (cmd.upd && (dv_q_q != '0) && (dv_q_q < best_q)) begin
			best_q <= dv_q_q;
			hit_q  <= 1'b1;
		end

		if (cmd.out_load) begin
			out_dist_q <= best_q;
			out_hit_q  <= hit_q;
		end
	end

	assign sts.a_zero   = (a_q == '0);
	assign sts.disc_neg = disc_neg_q;
	assign sts.num_bad  = num_bad_q;

	assign hit              = out_hit_q;
	assign nearest_distance = out_dist_q;

endmodule

>>> sv/nsh_ctrl.sv
// Sequencer: handshakes, sphere loop, and step counting for the datapath.
module nsh_ctrl #(
	parameter int MAX_SPHERES = nsh_pkg::NSH_MAX_SPHERES,
	localparam int AW    = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1,
	localparam int CNT_W = $clog2(MAX_SPHERES + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     kind,
	output logic                     out_valid,
	input  logic                     out_ready,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [nsh_pkg::CFG_W-1:0] cfg_data,
	output nsh_pkg::nsh_cmd_t        cmd,
	input  nsh_pkg::nsh_sts_t        sts,
	output logic [AW-1:0]            rd_addr
);
	import nsh_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_NEXT, S_LATCH, S_MUL, S_MWB, S_CHECK,
		S_SQRT, S_NUM, S_NCHK, S_DIV, S_UPD, S_DONE
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  ent_q;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        part_q;
	mul_op_t           op_q;
	logic [CFG_W-1:0]  count_q;
	logic              out_valid_q;

	logic       in_acc;
	logic [6:0] lim7;
	logic       more;
	logic       out_free;

	assign in_acc   = in_valid && (state_q == S_IDLE);
	assign lim7     = (7'(count_q) > 7'(MAX_SPHERES)) ? 7'(MAX_SPHERES) : 7'(count_q);
	assign more     = 7'(ent_q) < lim7;
	assign out_free = !out_valid_q || out_ready;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign rd_addr   = ent_q[AW-1:0];

	// Command decode
	always_comb begin
		cmd          = '0;
		cmd.mul_op   = op_q;
		cmd.mul_part = part_q;
		cmd.tbl_wr   = in_acc && (kind == KIND_LOAD);
		cmd.q_load   = in_acc && (kind == KIND_QUERY);
		cmd.ent_load = (state_q == S_LATCH);
		cmd.mul_step = (state_q == S_MUL);
		cmd.mul_wb   = (state_q == S_MWB);
		cmd.sq_step  = (state_q == S_SQRT);
		cmd.num_calc = (state_q == S_NUM);
		cmd.dv_step  = (state_q == S_DIV);
		cmd.upd      = (state_q == S_UPD);
		cmd.out_load = (state_q == S_DONE) && out_free;
	end

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ent_q       <= '0;
			step_q      <= '0;
			part_q      <= '0;
			op_q        <= OP_DL_X;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				count_q <= cfg_data;
			end
			// Result beat flag: set on a finished query, cleared once taken
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (kind == KIND_QUERY)) begin
						ent_q   <= '0;
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					state_q <= more ? S_LATCH : S_DONE;
				end
				S_LATCH: begin
					op_q    <= OP_DL_X;
					part_q  <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					part_q <= part_q + 2'd1;
					if (part_q == 2'd3) begin
						state_q <= S_MWB;
					end
				end
				S_MWB: begin
					if (op_q == OP_AC) begin
						state_q <= S_CHECK;
					end else begin
						op_q    <= mul_op_t'(op_q + 4'd1);
						state_q <= S_MUL;
					end
				end
				S_CHECK: begin
					step_q <= '0;
					if (sts.a_zero || sts.disc_neg) begin
						ent_q   <= ent_q + 1'b1;
						state_q <= S_NEXT;
					end else begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(SQ_W - 1)) begin
						state_q <= S_NUM;
					end
				end
				S_NUM: begin
					state_q <= S_NCHK;
				end
				S_NCHK: begin
					step_q <= '0;
					if (sts.num_bad) begin
						ent_q   <= ent_q + 1'b1;
						state_q <= S_NEXT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(Q_W - 1)) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					ent_q   <= ent_q + 1'b1;
					state_q <= S_NEXT;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> sv/nsh_checker.sv
// Port-level checks for the nearest sphere hit unit, bound to the top level.
module nsh_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       kind,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       hit,
	input logic [nsh_pkg::DIST_W-1:0] nearest_distance
);
	import nsh_pkg::*;

	// A result beat holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped before accept");

	// A miss reports the largest distance
	a_miss_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> nearest_distance == MISS_DIST)
		else $error("miss without all-ones distance");

	// A hit reports a positive distance below the miss value
	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> (nearest_distance != MISS_DIST) && (nearest_distance != '0))
		else $error("hit with out-of-range distance");

	// A load beat never produces a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == KIND_LOAD) |=> !$rose(out_valid))
		else $error("result after load beat");

endmodule

bind nearest_sphere_hit_unit nsh_checker u_nsh_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.kind            (kind),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.hit             (hit),
	.nearest_distance(nearest_distance)
);
